/* src/apc_pkg.sv */
package apc_pkg;

  // Depth and length bounds of the checker
  localparam int unsigned MaxDepth = 255;
  localparam int unsigned MaxLen   = 1024;
  localparam int unsigned DepthW   = 8;
  localparam int unsigned PosW     = 11;
  localparam int unsigned MaskW    = 5;

  // Character codes of interest
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;

  // Bits of the expected-class mask
  localparam int unsigned MaskBitZero  = 0;
  localparam int unsigned MaskBitDigit = 1;
  localparam int unsigned MaskBitOp    = 2;
  localparam int unsigned MaskBitOpen  = 3;
  localparam int unsigned MaskBitClose = 4;

  // Parser state, one-hot
  typedef enum logic [3:0] {
    StExpect = 4'b0001,
    StNumber = 4'b0010,
    StClosed = 4'b0100,
    StReject = 4'b1000
  } parse_state_e;

  // Character class
  typedef enum logic [2:0] {
    ClsZero  = 3'd0,
    ClsDigit = 3'd1,
    ClsOp    = 3'd2,
    ClsOpen  = 3'd3,
    ClsClose = 3'd4,
    ClsOther = 3'd5
  } char_cls_e;

  // Running state of one expression
  typedef struct packed {
    parse_state_e      parse;
    logic [DepthW-1:0] depth;
    logic              error_seen;
    logic [PosW-1:0]   error_pos;
    logic [MaskW-1:0]  error_mask;
    logic [PosW-1:0]   char_index;
    logic              overflow;
  } apc_state_t;

  // One result word
  typedef struct packed {
    logic             done_res;
    logic             accepted;
    logic [PosW-1:0]  error_pos;
    logic             error_after_end;
    logic [MaskW-1:0] expected_mask;
    logic             depth_overflow;
  } apc_res_t;

  localparam apc_state_t StateReset = '{
    parse:      StExpect,
    depth:      '0,
    error_seen: 1'b0,
    error_pos:  '0,
    error_mask: '0,
    char_index: '0,
    overflow:   1'b0
  };

  function automatic char_cls_e classify(logic [7:0] c);
    char_cls_e cls;
    cls = ClsOther;
    if (c == ChZero) begin
      cls = ClsZero;
    end else if (c >= ChOne && c <= ChNine) begin
      cls = ClsDigit;
    end else if (c == ChPlus || c == ChMinus || c == ChStar || c == ChSlash) begin
      cls = ClsOp;
    end else if (c == ChOpen) begin
      cls = ClsOpen;
    end else if (c == ChClose) begin
      cls = ClsClose;
    end
    return cls;
  endfunction

  function automatic logic [MaskW-1:0] allowed_mask(parse_state_e st, logic [DepthW-1:0] d);
    logic [MaskW-1:0] m;
    m = '0;
    unique case (st)
      StExpect: begin
        m[MaskBitDigit] = 1'b1;
        m[MaskBitOpen]  = (d < DepthW'(MaxDepth));
      end
      StNumber: begin
        m[MaskBitZero]  = 1'b1;
        m[MaskBitDigit] = 1'b1;
        m[MaskBitOp]    = 1'b1;
        m[MaskBitClose] = (d != '0);
      end
      StClosed: begin
        m[MaskBitOp]    = 1'b1;
        m[MaskBitClose] = (d != '0);
      end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* src/apc_if.sv */
// Character channel
interface apc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;
  logic       last;

  modport source (output valid, ch, first, last, input ready);
  modport sink   (input valid, ch, first, last, output ready);
endinterface

// Verdict channel
interface apc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         done_res;
  logic                         accepted;
  logic [apc_pkg::PosW-1:0]     error_pos;
  logic                         error_after_end;
  logic [apc_pkg::MaskW-1:0]    expected_mask;
  logic                         depth_overflow;

  modport source (output valid, done_res, accepted, error_pos, error_after_end,
                  expected_mask, depth_overflow, input ready);
  modport sink   (input valid, done_res, accepted, error_pos, error_after_end,
                  expected_mask, depth_overflow, output ready);
endinterface

/* src/apc_step.sv */
module apc_step (
  input  apc_pkg::apc_state_t state_i,
  input  logic [7:0]          ch_i,
  input  logic                first_i,
  input  logic                last_i,
  output apc_pkg::apc_state_t state_o,
  output apc_pkg::apc_res_t   res_o
);

  apc_pkg::apc_state_t       cur;
  apc_pkg::apc_state_t       nxt;
  apc_pkg::char_cls_e        cls;
  logic [apc_pkg::MaskW-1:0] mask;
  logic                      ok;

  // Start from cleared state on the first character
  assign cur  = first_i ? apc_pkg::StateReset : state_i;
  assign cls  = apc_pkg::classify(ch_i);
  assign mask = apc_pkg::allowed_mask(cur.parse, cur.depth);

  // Look up whether the class is allowed here
  always_comb begin
    case (cls)
      apc_pkg::ClsZero:  ok = mask[apc_pkg::MaskBitZero];
      apc_pkg::ClsDigit: ok = mask[apc_pkg::MaskBitDigit];
      apc_pkg::ClsOp:    ok = mask[apc_pkg::MaskBitOp];
      apc_pkg::ClsOpen:  ok = mask[apc_pkg::MaskBitOpen];
      apc_pkg::ClsClose: ok = mask[apc_pkg::MaskBitClose];
      default:           ok = 1'b0;
    endcase
  end

  // Advance the parser; skip spaces
  always_comb begin
    nxt = cur;
    if (ch_i != apc_pkg::ChSpace) begin
      if (ok) begin
        case (cls)
          apc_pkg::ClsOpen: begin
            nxt.depth = cur.depth + 1'b1;
            nxt.parse = apc_pkg::StExpect;
          end
          apc_pkg::ClsClose: begin
            nxt.depth = cur.depth - 1'b1;
            nxt.parse = apc_pkg::StClosed;
          end
          apc_pkg::ClsOp:    nxt.parse = apc_pkg::StExpect;
          default:           nxt.parse = apc_pkg::StNumber;
        endcase
      end else begin
        // Keep only the first error
        if (!cur.error_seen) begin
          nxt.error_seen = 1'b1;
          nxt.error_pos  = cur.char_index;
          nxt.error_mask = mask;
          nxt.overflow   = (cur.parse == apc_pkg::StExpect) && (cls == apc_pkg::ClsOpen);
        end
        nxt.parse = apc_pkg::StReject;
      end
      if (cur.char_index < apc_pkg::PosW'(apc_pkg::MaxLen)) begin
        nxt.char_index = cur.char_index + 1'b1;
      end
    end
  end

  assign state_o = nxt;

  // Form the verdict on the last character
  always_comb begin
    res_o = '0;
    if (last_i) begin
      res_o.done_res = 1'b1;
      if (!nxt.error_seen && (nxt.parse == apc_pkg::StNumber ||
          nxt.parse == apc_pkg::StClosed) && nxt.depth == '0) begin
        res_o.accepted = 1'b1;
      end else if (nxt.error_seen) begin
        res_o.error_pos      = nxt.error_pos;
        res_o.expected_mask  = nxt.error_mask;
        res_o.depth_overflow = nxt.overflow;
      end else begin
        res_o.error_pos       = nxt.char_index;
        res_o.error_after_end = 1'b1;
        res_o.expected_mask   = apc_pkg::allowed_mask(nxt.parse, nxt.depth);
      end
    end
  end

endmodule

/* src/arith_expression_pda_checker.sv */
// Arithmetic expression syntax checker.
// Characters arrive on in_i, one word per character, with first marking the
// start of an expression (all parse state cleared) and last marking its end.
// Every accepted character yields exactly one word on out_o; only the word for
// a last character carries a verdict (done_res set), the others are all zero.
// Spaces are skipped and not counted in the error position.
// A character accepted into the input register passes through the parse step
// into the result register, which drives out_o.
// Throughput: one character per cycle while out_o does not stall; the parse
// step between the input register and the result register is combinational;
// state is updated in the same cycle the character leaves the input register.
// Reset clears the parse state and both valid flags; the first expression
// may start without the first flag.
// When out_o stalls, the result register holds and the input register keeps
// one more character; in_i.ready falls only when both are full.
module arith_expression_pda_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  apc_in_if.sink    in_i,
  apc_out_if.source out_o
);

  logic                s1_valid_q;
  logic [7:0]          s1_ch_q;
  logic                s1_first_q;
  logic                s1_last_q;
  logic                s1_adv;
  logic                out_valid_q;
  apc_pkg::apc_res_t   res_q;
  apc_pkg::apc_res_t   res_d;
  apc_pkg::apc_state_t state_q;
  apc_pkg::apc_state_t state_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  // Capture the input word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_ch_q    <= in_i.ch;
      s1_first_q <= in_i.first;
      s1_last_q  <= in_i.last;
    end
  end

  apc_step u_step (
    .state_i (state_q),
    .ch_i    (s1_ch_q),
    .first_i (s1_first_q),
    .last_i  (s1_last_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Update the parse state as the word moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apc_pkg::StateReset;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.done_res        = res_q.done_res;
  assign out_o.accepted        = res_q.accepted;
  assign out_o.error_pos       = res_q.error_pos;
  assign out_o.error_after_end = res_q.error_after_end;
  assign out_o.expected_mask   = res_q.expected_mask;
  assign out_o.depth_overflow  = res_q.depth_overflow;

endmodule
